// File: rtl/gtpie_pkg.sv
// shared types, codes and the element type table for the gtpv0 ie stream parser
// no dependencies; used by every module in rtl/

package gtpie_pkg;

    // input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic [7:0]  ie_type;
        logic [7:0]  value_byte;
        logic        value_valid;
        logic [15:0] value_index;
        logic        ie_done;
        logic [15:0] ie_length;
        logic [31:0] value_word;
        logic [2:0]  status;
        logic        gsn_second;
        logic        msg_end;
    } result_t;

    // element kinds
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_DECODE  = 2'd1;
    localparam logic [1:0] KIND_SKIP    = 2'd2;
    localparam logic [1:0] KIND_TLV     = 2'd3;

    // status codes
    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_DECODED   = 3'd1;
    localparam logic [2:0] ST_SKIPPED   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_BAD_LEN   = 3'd5;

    // element types with special handling
    localparam logic [7:0] TYPE_SELECTION = 8'h0F;
    localparam logic [7:0] TYPE_EUA       = 8'h80;
    localparam logic [7:0] TYPE_APN       = 8'h83;
    localparam logic [7:0] TYPE_GSN       = 8'h85;
    localparam logic [7:0] TLV_FIRST      = 8'h80;
    localparam logic [7:0] TLV_LAST       = 8'h86;

    // apn character handling
    localparam logic [7:0] APN_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] APN_DOT        = 8'h2E;

    // valid lengths for end user address and gsn address
    localparam logic [15:0] EUA_LEN_A = 16'd2;
    localparam logic [15:0] EUA_LEN_B = 16'd6;
    localparam logic [15:0] EUA_LEN_C = 16'd18;
    localparam logic [15:0] EUA_LEN_D = 16'd22;
    localparam logic [15:0] GSN_LEN_V4 = 16'd4;
    localparam logic [15:0] GSN_LEN_V6 = 16'd16;

    // apn length limit after reset
    localparam logic [7:0] APN_MAX_RESET = 8'd100;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] len;
    } type_info_t;

    // fixed-length table lookup; tlv and unknown types give length zero
    function automatic type_info_t type_lookup(input logic [7:0] t);
        type_info_t info;
        info.kind = KIND_DECODE;
        info.len  = 5'd0;
        unique case (t)
            8'h01: info.len = 5'd1;
            8'h02: info.len = 5'd8;
            8'h03: info.len = 5'd6;
            8'h04: begin info.kind = KIND_SKIP; info.len = 5'd4; end
            8'h05: begin info.kind = KIND_SKIP; info.len = 5'd4; end
            8'h06: info.len = 5'd3;
            8'h08: info.len = 5'd1;
            8'h09: begin info.kind = KIND_SKIP; info.len = 5'd28; end
            8'h0B: begin info.kind = KIND_SKIP; info.len = 5'd1; end
            8'h0C: begin info.kind = KIND_SKIP; info.len = 5'd3; end
            8'h0D: begin info.kind = KIND_SKIP; info.len = 5'd1; end
            8'h0E: info.len = 5'd1;
            8'h0F: info.len = 5'd1;
            8'h10: info.len = 5'd2;
            8'h11: info.len = 5'd2;
            8'h12: begin info.kind = KIND_SKIP; info.len = 5'd3; end
            8'h13: begin info.kind = KIND_SKIP; info.len = 5'd1; end
            8'h7F: info.len = 5'd4;
            default:
            begin
                if (t >= TLV_FIRST && t <= TLV_LAST)
                    info.kind = KIND_TLV;
                else
                    info.kind = KIND_UNKNOWN;
            end
        endcase
        return info;
    endfunction

endpackage

// File: rtl/gtpie_in_reg.sv
// input holding register between the byte stream and the parse core
// depends on gtpie_pkg for the input payload type

module gtpie_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  gtpie_pkg::in_item_t item,
    output logic               hold_valid,
    input  logic               hold_ready,
    output gtpie_pkg::in_item_t hold_item
);

    logic                valid_reg;
    logic                valid_next;
    gtpie_pkg::in_item_t item_reg;

    // take a new transfer when empty or when the held one moves on
    assign item_ready = !valid_reg || hold_ready;
    assign valid_next = item_valid || (valid_reg && !hold_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload load
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

// File: rtl/gtpie_parse_core.sv
// element segmentation state, per-byte decode logic and the result register
// depends on gtpie_pkg for payload types, codes and the type table

module gtpie_parse_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gtpie_pkg::in_item_t in_item,
    input  logic [7:0]          apn_max_length,
    output logic                result_valid,
    input  logic                result_ready,
    output gtpie_pkg::result_t  result
);

    localparam logic [1:0] PH_TYPE   = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;
    localparam logic [1:0] PH_VALUE  = 2'd3;

    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  type_reg,   type_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] count_reg,  count_next;
    logic [31:0] word_reg,   word_next;
    logic        gsn_reg,    gsn_next;
    logic        strip_reg,  strip_next;
    logic        stop_reg,   stop_next;
    logic        halted_reg, halted_next;
    logic        res_valid_reg, res_valid_next;
    gtpie_pkg::result_t res_reg, res_next;

    logic                  advance;
    logic [7:0]            b;
    logic                  last;
    logic                  fin;
    logic [15:0]           count_inc;
    gtpie_pkg::type_info_t new_info;
    gtpie_pkg::type_info_t cur_info;

    // result register frees when empty or taken
    assign in_ready = !res_valid_reg || result_ready;
    assign advance  = in_valid && in_ready;
    assign res_valid_next = advance || (res_valid_reg && !result_ready);

    assign b         = in_item.data_byte;
    assign last      = in_item.last_byte;
    assign count_inc = count_reg + 16'd1;
    assign new_info  = gtpie_pkg::type_lookup(b);
    assign cur_info  = gtpie_pkg::type_lookup(type_reg);

    // per-byte parse step
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        word_next   = word_reg;
        gsn_next    = gsn_reg;
        strip_next  = strip_reg;
        stop_next   = stop_reg;
        halted_next = halted_reg;
        fin         = 1'b0;
        res_next    = '0;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = b;
                    word_next  = 32'd0;
                    count_next = 16'd0;
                    strip_next = 1'b1;
                    stop_next  = 1'b0;
                    if (new_info.kind == gtpie_pkg::KIND_UNKNOWN)
                    begin
                        res_next.ie_done = 1'b1;
                        res_next.status  = gtpie_pkg::ST_UNKNOWN;
                        halted_next      = 1'b1;
                    end
                    else if (new_info.kind == gtpie_pkg::KIND_TLV)
                    begin
                        len_next   = 16'd0;
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        len_next   = {11'd0, new_info.len};
                        phase_next = PH_VALUE;
                    end
                end
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = {len_reg[15:8], b};
                    if ({len_reg[15:8], b} == 16'd0)
                        fin = 1'b1;
                    else
                        phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    res_next.value_index = count_reg;
                    // packed value word
                    if (type_reg == gtpie_pkg::TYPE_EUA)
                    begin
                        if (count_reg == 16'd0)
                            word_next = {20'd0, b[3:0], 8'h00};
                        else if (count_reg == 16'd1)
                            word_next = word_reg | {24'd0, b};
                    end
                    else if (type_reg == gtpie_pkg::TYPE_SELECTION)
                        word_next = {30'd0, b[1:0]};
                    else
                        word_next = {word_reg[23:0], b};
                    // value byte stream, apn cleanup
                    if (type_reg == gtpie_pkg::TYPE_APN)
                    begin
                        if (stop_reg || (strip_reg && b < gtpie_pkg::APN_CTRL_LIMIT))
                            res_next.value_index = 16'd0;
                        else
                        begin
                            strip_next = 1'b0;
                            if (b == 8'h00)
                            begin
                                stop_next            = 1'b1;
                                res_next.value_index = 16'd0;
                            end
                            else
                            begin
                                res_next.value_byte  = (b < gtpie_pkg::APN_CTRL_LIMIT)
                                                       ? gtpie_pkg::APN_DOT : b;
                                res_next.value_valid = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        res_next.value_byte  = b;
                        res_next.value_valid = 1'b1;
                    end
                    count_next = count_inc;
                    if (count_inc == len_reg)
                        fin = 1'b1;
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase

            // element completion
            if (fin)
            begin
                res_next.ie_done    = 1'b1;
                res_next.ie_length  = len_next;
                res_next.value_word = word_next;
                res_next.status     = (cur_info.kind == gtpie_pkg::KIND_SKIP)
                                      ? gtpie_pkg::ST_SKIPPED : gtpie_pkg::ST_DECODED;
                phase_next          = PH_TYPE;
                if (type_reg == gtpie_pkg::TYPE_EUA)
                begin
                    if (len_next != gtpie_pkg::EUA_LEN_A && len_next != gtpie_pkg::EUA_LEN_B
                        && len_next != gtpie_pkg::EUA_LEN_C
                        && len_next != gtpie_pkg::EUA_LEN_D)
                        res_next.status = gtpie_pkg::ST_BAD_LEN;
                end
                else if (type_reg == gtpie_pkg::TYPE_APN)
                begin
                    if (len_next >= {8'h00, apn_max_length})
                    begin
                        res_next.status = gtpie_pkg::ST_BAD_LEN;
                        halted_next     = 1'b1;
                    end
                end
                else if (type_reg == gtpie_pkg::TYPE_GSN)
                begin
                    res_next.gsn_second = gsn_reg;
                    if (len_next == gtpie_pkg::GSN_LEN_V4 || len_next == gtpie_pkg::GSN_LEN_V6)
                        gsn_next = 1'b1;
                    else
                        res_next.status = gtpie_pkg::ST_BAD_LEN;
                end
            end

            // message ends inside an element
            if (last && !res_next.ie_done && phase_next != PH_TYPE)
            begin
                res_next.ie_done    = 1'b1;
                res_next.ie_length  = count_next;
                res_next.value_word = 32'd0;
                res_next.status     = gtpie_pkg::ST_TRUNCATED;
                res_next.gsn_second = 1'b0;
            end
        end

        // message end clears per-message state
        if (last)
        begin
            phase_next       = PH_TYPE;
            halted_next      = 1'b0;
            gsn_next         = 1'b0;
            res_next.msg_end = 1'b1;
        end
        res_next.ie_type = type_next;
    end

    // parse state, updated once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= 8'd0;
            len_reg    <= 16'd0;
            count_reg  <= 16'd0;
            word_reg   <= 32'd0;
            gsn_reg    <= 1'b0;
            strip_reg  <= 1'b1;
            stop_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            word_reg   <= word_next;
            gsn_reg    <= gsn_next;
            strip_reg  <= strip_next;
            stop_reg   <= stop_next;
            halted_reg <= halted_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    // a message end returns the parser to a clean start
    a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> phase_reg == PH_TYPE && !halted_reg && !gsn_reg)
        else $error("parser state not cleared after message end");

    // halting only ever happens between elements
    a_halt_at_type: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> phase_reg == PH_TYPE)
        else $error("parser halted inside an element");

    // value phase always has bytes left to take
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> count_reg < len_reg)
        else $error("value byte count ran past element length");

    // done-only fields stay zero on busy results
    a_busy_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ie_done |-> result.status == gtpie_pkg::ST_BUSY
            && result.ie_length == 16'd0 && result.value_word == 32'd0)
        else $error("busy result carries element completion fields");
`endif

endmodule

// File: rtl/gtpv0_ie_stream_parser.sv
// gtpv0 ie stream parser: an input transfer passes the input register, then the
// result register; throughput is one byte per cycle while result_ready stays high,
// set by the combinational parse step that updates the element state for every byte.
// rst_n is asynchronous active low; it returns the parser to expect-type with no
// pending transfers and sets apn_max_length to 100. no clearing pass is needed.
// depends on gtpie_pkg, gtpie_in_reg and gtpie_parse_core

module gtpv0_ie_stream_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  gtpie_pkg::in_item_t item,
    output logic                result_valid,
    input  logic                result_ready,
    output gtpie_pkg::result_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic [7:0]          apn_max_reg;
    logic                hold_valid;
    logic                hold_ready;
    gtpie_pkg::in_item_t hold_item;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            apn_max_reg <= gtpie_pkg::APN_MAX_RESET;
        else if (cfg_valid && cfg_ready)
            apn_max_reg <= cfg_data;
    end

    // input stage
    gtpie_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .hold_valid (hold_valid),
        .hold_ready (hold_ready),
        .hold_item  (hold_item)
    );

    // parse step and result register
    gtpie_parse_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (hold_valid),
        .in_ready       (hold_ready),
        .in_item        (hold_item),
        .apn_max_length (apn_max_reg),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result)
    );

endmodule

// File: test/gtpv0_ie_stream_parser_tb.sv
// self-checking testbench for the gtpv0 ie stream parser: byte streams in, one result per byte
// predicts every result with its own parser model and checks each field of every result
// depends on gtpie_pkg and gtpv0_ie_stream_parser

module gtpv0_ie_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_BYTE = 400;
    localparam int PHASE_BYTES  = 190;
    localparam int DRAIN_LIMIT  = 200000;

    typedef enum logic [1:0] {SEEK_TYPE, LEN_HIGH, LEN_LOW, IN_VALUE} parse_phase_e;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    gtpie_pkg::in_item_t in_item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    gtpie_pkg::result_t  result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data = 8'd0;

    // parser model state
    parse_phase_e ph = SEEK_TYPE;
    logic [7:0]   cur_type = 8'd0;
    logic [15:0]  vlen = 16'd0;
    logic [15:0]  vcount = 16'd0;
    logic [31:0]  vword = 32'd0;
    bit           gsn_filled = 1'b0;
    bit           apn_strip = 1'b1;
    bit           apn_stop = 1'b0;
    bit           halted = 1'b0;
    logic [7:0]   apn_limit = gtpie_pkg::APN_MAX_RESET;

    // byte streams waiting to go out and results still owed by the block
    gtpie_pkg::in_item_t ie_bytes_todo[$];
    gtpie_pkg::result_t  ie_results_due[$];
    logic [7:0]          msg_buf[$];

    bit hold_off = 1'b0;
    bit item_took = 1'b0;
    int tx_wait = 0;
    int tx_calm = 0;
    int rx_wait = 0;
    int rx_calm = 0;
    int items_in = 0;
    int results_out = 0;
    int fault_count = 0;
    int bytes_queued = 0;
    int messages = 0;
    int limit_settings = 0;
    int done_by_status[8];

    gtpv0_ie_stream_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (in_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // element kind and fixed value length of a type code
    function automatic logic [1:0] classify(input logic [7:0] t, output logic [15:0] flen);
        logic [1:0] kind;
        kind = gtpie_pkg::KIND_DECODE;
        flen = 16'd0;
        case (t)
            8'h01, 8'h08, 8'h0E, 8'h0F: flen = 16'd1;
            8'h02: flen = 16'd8;
            8'h03: flen = 16'd6;
            8'h06: flen = 16'd3;
            8'h10, 8'h11: flen = 16'd2;
            8'h7F: flen = 16'd4;
            8'h04, 8'h05:
            begin
                kind = gtpie_pkg::KIND_SKIP;
                flen = 16'd4;
            end
            8'h09:
            begin
                kind = gtpie_pkg::KIND_SKIP;
                flen = 16'd28;
            end
            8'h0B, 8'h0D, 8'h13:
            begin
                kind = gtpie_pkg::KIND_SKIP;
                flen = 16'd1;
            end
            8'h0C, 8'h12:
            begin
                kind = gtpie_pkg::KIND_SKIP;
                flen = 16'd3;
            end
            default:
                kind = (t >= gtpie_pkg::TLV_FIRST && t <= gtpie_pkg::TLV_LAST)
                       ? gtpie_pkg::KIND_TLV : gtpie_pkg::KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

    // element complete: status, length and packed word
    function automatic void close_element(inout gtpie_pkg::result_t r);
        logic [15:0] spare;
        logic [2:0]  st;
        st = (classify(cur_type, spare) == gtpie_pkg::KIND_SKIP)
             ? gtpie_pkg::ST_SKIPPED : gtpie_pkg::ST_DECODED;
        if (cur_type == gtpie_pkg::TYPE_EUA)
        begin
            if (vlen != gtpie_pkg::EUA_LEN_A && vlen != gtpie_pkg::EUA_LEN_B
                && vlen != gtpie_pkg::EUA_LEN_C && vlen != gtpie_pkg::EUA_LEN_D)
                st = gtpie_pkg::ST_BAD_LEN;
        end
        else if (cur_type == gtpie_pkg::TYPE_APN)
        begin
            if (vlen >= {8'd0, apn_limit})
            begin
                st = gtpie_pkg::ST_BAD_LEN;
                halted = 1'b1;
            end
        end
        else if (cur_type == gtpie_pkg::TYPE_GSN)
        begin
            r.gsn_second = gsn_filled;
            if (vlen == gtpie_pkg::GSN_LEN_V4 || vlen == gtpie_pkg::GSN_LEN_V6)
                gsn_filled = 1'b1;
            else
                st = gtpie_pkg::ST_BAD_LEN;
        end
        r.ie_done    = 1'b1;
        r.ie_length  = vlen;
        r.value_word = vword;
        r.status     = st;
        ph = SEEK_TYPE;
    endfunction

    // advance the parser model by one byte and give the result it should produce
    function automatic gtpie_pkg::result_t parse_ie_byte(input gtpie_pkg::in_item_t it);
        gtpie_pkg::result_t r;
        logic [7:0]         b;
        logic [1:0]         k;
        logic [15:0]        flen;
        b = it.data_byte;
        r = '0;
        if (!halted)
        begin
            case (ph)
                SEEK_TYPE:
                begin
                    cur_type  = b;
                    vword     = 32'd0;
                    vcount    = 16'd0;
                    apn_strip = 1'b1;
                    apn_stop  = 1'b0;
                    k = classify(b, flen);
                    if (k == gtpie_pkg::KIND_UNKNOWN)
                    begin
                        r.ie_done = 1'b1;
                        r.status  = gtpie_pkg::ST_UNKNOWN;
                        halted    = 1'b1;
                    end
                    else if (k == gtpie_pkg::KIND_TLV)
                    begin
                        vlen = 16'd0;
                        ph   = LEN_HIGH;
                    end
                    else
                    begin
                        vlen = flen;
                        ph   = IN_VALUE;
                    end
                end
                LEN_HIGH:
                begin
                    vlen = {b, 8'h00};
                    ph   = LEN_LOW;
                end
                LEN_LOW:
                begin
                    vlen = {vlen[15:8], b};
                    if (vlen == 16'd0)
                        close_element(r);
                    else
                        ph = IN_VALUE;
                end
                default:
                begin
                    r.value_index = vcount;
                    // packed word: eua keeps org and number, selection mode keeps two bits
                    if (cur_type == gtpie_pkg::TYPE_EUA)
                    begin
                        if (vcount == 16'd0)
                            vword = {20'd0, b[3:0], 8'd0};
                        else if (vcount == 16'd1)
                            vword[7:0] = b;
                    end
                    else if (cur_type == gtpie_pkg::TYPE_SELECTION)
                        vword = {30'd0, b[1:0]};
                    else
                        vword = {vword[23:0], b};
                    // apn: drop control prefix, stop at nul, later controls become dots
                    if (cur_type == gtpie_pkg::TYPE_APN)
                    begin
                        if (apn_stop || (apn_strip && b < gtpie_pkg::APN_CTRL_LIMIT))
                            r.value_index = 16'd0;
                        else
                        begin
                            apn_strip = 1'b0;
                            if (b == 8'd0)
                            begin
                                apn_stop = 1'b1;
                                r.value_index = 16'd0;
                            end
                            else
                            begin
                                r.value_byte  = (b < gtpie_pkg::APN_CTRL_LIMIT)
                                                ? gtpie_pkg::APN_DOT : b;
                                r.value_valid = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        r.value_byte  = b;
                        r.value_valid = 1'b1;
                    end
                    vcount = vcount + 16'd1;
                    if (vcount == vlen)
                        close_element(r);
                end
            endcase
            // message ends inside an element
            if (it.last_byte && !r.ie_done && ph != SEEK_TYPE)
            begin
                r.ie_done    = 1'b1;
                r.ie_length  = vcount;
                r.value_word = 32'd0;
                r.status     = gtpie_pkg::ST_TRUNCATED;
                r.gsn_second = 1'b0;
            end
        end
        if (it.last_byte)
        begin
            ph         = SEEK_TYPE;
            halted     = 1'b0;
            gsn_filled = 1'b0;
            r.msg_end  = 1'b1;
        end
        r.ie_type = cur_type;
        return r;
    endfunction

    function automatic void flag_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want)
            flag_fault($sformatf("result %0d %s: expected %0h, got %0h",
                                 results_out, name, want, got));
    endfunction

    // mostly no gap, sometimes short or long, with calm stretches of none
    function automatic int draw_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 999);
        if (roll < 15)
        begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (roll < 600)
            return 0;
        if (roll < 900)
            return $urandom_range(1, 3);
        if (roll < 980)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] apn_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 8'h00;
        if (roll < 20)
            return 8'($urandom_range(1, 31));
        if (roll < 30)
            return 8'($urandom_range(128, 255));
        if (roll < 40)
            return gtpie_pkg::APN_DOT;
        return 8'($urandom_range(32, 127));
    endfunction

    // move the assembled message to the send queue, last flag on its final byte
    task automatic post_message();
        gtpie_pkg::in_item_t it;
        for (int i = 0; i < msg_buf.size(); i++)
        begin
            it.data_byte = msg_buf[i];
            it.last_byte = (i == msg_buf.size() - 1);
            ie_bytes_todo.push_back(it);
        end
        bytes_queued += msg_buf.size();
        messages++;
    endtask

    task automatic add_tlv(input logic [7:0] t, input logic [15:0] len);
        msg_buf.push_back(t);
        msg_buf.push_back(len[15:8]);
        msg_buf.push_back(len[7:0]);
        repeat (len) msg_buf.push_back((t == gtpie_pkg::TYPE_APN) ? apn_char() : 8'($urandom));
    endtask

    task automatic add_random_element();
        logic [7:0]  t;
        logic [15:0] n;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            // fixed-length element
            if ($urandom_range(0, 9) == 0)
                t = 8'h7F;
            else
            begin
                t = 8'h00;
                while (classify(t, n) == gtpie_pkg::KIND_UNKNOWN)
                    t = 8'($urandom_range(1, 19));
            end
            void'(classify(t, n));
            msg_buf.push_back(t);
            repeat (n) msg_buf.push_back(8'($urandom));
        end
        else if (roll < 50)
        begin
            case ($urandom_range(0, 4))
                0: n = gtpie_pkg::EUA_LEN_A;
                1: n = gtpie_pkg::EUA_LEN_B;
                2: n = gtpie_pkg::EUA_LEN_C;
                3: n = gtpie_pkg::EUA_LEN_D;
                default: n = 16'($urandom_range(0, 30));
            endcase
            add_tlv(gtpie_pkg::TYPE_EUA, n);
        end
        else if (roll < 65)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                n = 16'($urandom_range(250, 300));
            else if (roll < 15)
                n = 16'($urandom_range(31, 80));
            else
                n = 16'($urandom_range(0, 30));
            add_tlv(gtpie_pkg::TYPE_APN, n);
        end
        else if (roll < 80)
        begin
            if ($urandom_range(0, 9) < 8)
                n = $urandom_range(0, 1) ? gtpie_pkg::GSN_LEN_V4 : gtpie_pkg::GSN_LEN_V6;
            else
                n = 16'($urandom_range(0, 20));
            add_tlv(gtpie_pkg::TYPE_GSN, n);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: t = 8'h81;
                1: t = 8'h82;
                2: t = 8'h84;
                default: t = 8'h86;
            endcase
            n = ($urandom_range(0, 99) < 3) ? 16'($urandom_range(256, 300))
                                            : 16'($urandom_range(0, 12));
            add_tlv(t, n);
        end
    endtask

    task automatic make_message();
        logic [7:0]  t;
        logic [15:0] n;
        int          roll;
        msg_buf.delete();
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            // pure noise
            repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom));
        end
        else if (roll < 7)
        begin
            // tlv with a long length, cut short by the message end
            n = 16'($urandom_range(256, 65535));
            msg_buf.push_back(8'($urandom_range(gtpie_pkg::TLV_FIRST, gtpie_pkg::TLV_LAST)));
            msg_buf.push_back(n[15:8]);
            msg_buf.push_back(n[7:0]);
            repeat ($urandom_range(0, 6)) msg_buf.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 6)) add_random_element();
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                // unknown type followed by bytes that must be ignored
                do
                    t = 8'($urandom);
                while (classify(t, n) != gtpie_pkg::KIND_UNKNOWN);
                msg_buf.push_back(t);
                repeat ($urandom_range(0, 5)) msg_buf.push_back(8'($urandom));
            end
            else if (roll < 20)
            begin
                // truncate somewhere in the message
                n = 16'($urandom_range(1, msg_buf.size()));
                while (msg_buf.size() > n)
                    void'(msg_buf.pop_back());
            end
        end
        post_message();
    endtask

    task automatic wait_for_idle();
        int guard;
        guard = 0;
        while ((ie_bytes_todo.size() != 0 || item_valid || ie_results_due.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    // new apn limit while idle, then a batch of random messages
    task automatic run_random_phase(input logic [7:0] limit);
        int start;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_settings++;
        start = bytes_queued;
        while (bytes_queued - start < PHASE_BYTES)
            make_message();
        wait_for_idle();
    endtask

    // byte driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_took))
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                item_valid <= 1'b0;
            end
            else if (ie_bytes_todo.size() > 0)
            begin
                in_item    <= ie_bytes_todo.pop_front();
                item_valid <= 1'b1;
                tx_wait = draw_gap(tx_calm);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            result_ready <= 1'b0;
        else if (rx_wait > 0)
        begin
            rx_wait--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            rx_wait = draw_gap(rx_calm);
        end
    end

    // monitor: config and byte transfers feed the model, result transfers are checked
    always @(posedge clk)
    begin
        gtpie_pkg::result_t want;
        item_took <= item_valid && item_ready;
        if (cfg_valid && cfg_ready)
            apn_limit = cfg_data;
        if (item_valid && item_ready)
        begin
            ie_results_due.push_back(parse_ie_byte(in_item));
            items_in++;
        end
        if (result_valid && result_ready)
        begin
            results_out++;
            if (ie_results_due.size() == 0)
                flag_fault($sformatf("result %0d arrived with nothing expected", results_out));
            else
            begin
                want = ie_results_due.pop_front();
                if (want.ie_done)
                    done_by_status[want.status]++;
                cmp_field("ie_type", want.ie_type, result.ie_type);
                cmp_field("value_byte", want.value_byte, result.value_byte);
                cmp_field("value_valid", want.value_valid, result.value_valid);
                cmp_field("value_index", want.value_index, result.value_index);
                cmp_field("ie_done", want.ie_done, result.ie_done);
                cmp_field("ie_length", want.ie_length, result.ie_length);
                cmp_field("value_word", want.value_word, result.value_word);
                cmp_field("status", want.status, result.status);
                cmp_field("gsn_second", want.gsn_second, result.gsn_second);
                cmp_field("msg_end", want.msg_end, result.msg_end);
            end
        end
    end

    // long receiver hold-off while bytes keep coming, to back up the input
    initial
    begin
        wait (items_in >= HOLD_AT_BYTE);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // reset, directed messages, then random phases at several apn limits
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unknown type zero as a whole message
        msg_buf = '{8'h00};
        post_message();
        // selection mode masked to two bits
        msg_buf = '{8'h0F, 8'hFF};
        post_message();
        // zero tlv length completes on the length
        msg_buf = '{8'h84, 8'h00, 8'h00};
        post_message();
        // end user address org and number
        msg_buf = '{8'h80, 8'h00, 8'h02, 8'hFF, 8'h21};
        post_message();
        // apn: control prefix dropped, control mapped to dot, high byte kept, nul stops
        msg_buf = '{8'h83, 8'h00, 8'h05, 8'h03, 8'h61, 8'h05, 8'h80, 8'h00};
        post_message();
        // unknown type 0xff halts until the end of the message
        msg_buf = '{8'hFF, 8'h12};
        post_message();
        // maximum tlv length, truncated
        msg_buf = '{8'h86, 8'hFF, 8'hFF, 8'hAB};
        post_message();
        wait_for_idle();

        run_random_phase(8'd255);
        run_random_phase(8'd1);
        run_random_phase(8'd12);
        run_random_phase(8'd64);

        if (ie_results_due.size() != 0)
            flag_fault($sformatf("%0d results never arrived", ie_results_due.size()));

        $display("covered %0d bytes in %0d messages, %0d apn limit settings, %0d results checked",
                 items_in, messages, limit_settings, results_out);
        $display("elements: %0d decoded, %0d skipped, %0d truncated, %0d unknown, %0d bad length",
                 done_by_status[gtpie_pkg::ST_DECODED], done_by_status[gtpie_pkg::ST_SKIPPED],
                 done_by_status[gtpie_pkg::ST_TRUNCATED], done_by_status[gtpie_pkg::ST_UNKNOWN],
                 done_by_status[gtpie_pkg::ST_BAD_LEN]);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: gtpv0_ie_stream_parser.f
rtl/gtpie_pkg.sv
rtl/gtpie_in_reg.sv
rtl/gtpie_parse_core.sv
rtl/gtpv0_ie_stream_parser.sv
test/gtpv0_ie_stream_parser_tb.sv
